// ===== src/lec_pkg.sv =====
package lec_pkg;

  // Fixed widths of the channel payloads.
  localparam int SAMPLE_W = 14;
  localparam int BYTE_W   = 8;

  // Defaults for the top-level parameters.
  localparam int SAMPLE_BITS_DEF = 14;
  localparam int FIFO_DEPTH_DEF  = 4;

  // Bit lengths below this use the short prefix table.
  localparam int SHORT_LIMIT = 5;

  // Pending bits kept between words: always fewer than one byte.
  localparam int PEND_W = 7;

  // Longest code word: prefix plus magnitude bits.
  function automatic int code_width(input int sample_bits);
    int long_code;
    int short_code_w;
    long_code    = 2 * sample_bits - 2;
    short_code_w = sample_bits + 3;
    return (long_code > short_code_w) ? long_code : short_code_w;
  endfunction

  function automatic logic [2:0] short_code(input logic [2:0] n);
    logic [2:0] code;
    unique case (n)
      3'd0:    code = 3'd0;
      3'd1:    code = 3'd2;
      3'd2:    code = 3'd3;
      3'd3:    code = 3'd4;
      3'd4:    code = 3'd5;
      default: code = 3'd0;
    endcase
    return code;
  endfunction

  function automatic logic [1:0] short_len(input logic [2:0] n);
    return (n == 3'd0) ? 2'd2 : 2'd3;
  endfunction

endpackage

// ===== src/lec_in_if.sv =====
interface lec_in_if;
  import lec_pkg::*;

  logic                valid;
  logic                ready;
  logic [SAMPLE_W-1:0] sample;
  logic                end_of_block;

  modport source (output valid, output sample, output end_of_block, input ready);
  modport sink   (input valid, input sample, input end_of_block, output ready);
endinterface

// ===== src/lec_out_if.sv =====
interface lec_out_if;
  import lec_pkg::*;

  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] out_byte;
  logic              last_of_run;

  modport source (output valid, output out_byte, output last_of_run, input ready);
  modport sink   (input valid, input out_byte, input last_of_run, output ready);
endinterface

// ===== src/lec_front.sv =====
module lec_front #(
  parameter int SAMPLE_BITS = lec_pkg::SAMPLE_BITS_DEF,
  parameter int CODE_W      = lec_pkg::code_width(lec_pkg::SAMPLE_BITS_DEF),
  parameter int LEN_W       = $clog2(lec_pkg::code_width(lec_pkg::SAMPLE_BITS_DEF) + 1)
) (
  input  logic              clk,
  input  logic              rst,
  lec_in_if.sink            din,
  input  logic              full,
  output logic              push,
  output logic [CODE_W-1:0] code,
  output logic [LEN_W-1:0]  len,
  output logic              eob
);
  import lec_pkg::*;

  localparam int N_W = $clog2(SAMPLE_BITS + 1);

  logic [SAMPLE_BITS-1:0] previous_sample;
  logic [SAMPLE_BITS-1:0] cur;
  logic [SAMPLE_BITS:0]   diff;
  logic [SAMPLE_BITS:0]   diff_m1;
  logic [SAMPLE_BITS:0]   diff_neg;
  logic                   neg;
  logic [SAMPLE_BITS-1:0] mag;
  logic [SAMPLE_BITS-1:0] val;
  logic [SAMPLE_BITS-1:0] val_mask;
  logic [N_W-1:0]         n;
  logic                   is_short;
  logic [LEN_W-1:0]       plen;
  logic [CODE_W-1:0]      pmask;
  logic [CODE_W-1:0]      prefix;

  assign din.ready = !full;
  assign push      = din.valid && !full;
  assign eob       = din.end_of_block;

  assign cur      = din.sample[SAMPLE_BITS-1:0];
  assign diff     = {1'b0, cur} - {1'b0, previous_sample};
  assign diff_m1  = diff - {{SAMPLE_BITS{1'b0}}, 1'b1};
  assign diff_neg = ~diff + {{SAMPLE_BITS{1'b0}}, 1'b1};
  assign neg      = diff[SAMPLE_BITS];
  assign mag      = neg ? diff_neg[SAMPLE_BITS-1:0] : diff[SAMPLE_BITS-1:0];
  // Negative differences carry the low bits of d-1, i.e. the one's complement.
  assign val      = neg ? diff_m1[SAMPLE_BITS-1:0] : diff[SAMPLE_BITS-1:0];

  // Bit length of the magnitude: highest set bit wins.
  always_comb begin
    n = '0;
    for (int i = 0; i < SAMPLE_BITS; i++) begin
      if (mag[i]) begin
        n = N_W'(i + 1);
      end
    end
  end

  always_comb begin
    for (int i = 0; i < SAMPLE_BITS; i++) begin
      val_mask[i] = (i < int'(n));
    end
  end

  assign is_short = (int'(n) < SHORT_LIMIT);

  always_comb begin
    if (is_short) begin
      plen = LEN_W'(short_len(3'(n)));
    end else begin
      plen = LEN_W'(int'(n) - 2);
    end
  end

  // Long prefixes are plen-1 ones followed by a zero, i.e. 2^plen - 2.
  always_comb begin
    for (int i = 0; i < CODE_W; i++) begin
      pmask[i] = (i < int'(plen));
    end
  end

  assign prefix = is_short ? CODE_W'(short_code(3'(n)))
                           : (pmask & ~CODE_W'(1));
  assign code   = (prefix << n) | CODE_W'(val & val_mask);
  assign len    = LEN_W'(int'(plen) + int'(n));

  always_ff @(posedge clk) begin
    if (rst) begin
      previous_sample <= '0;
    end else if (push) begin
      previous_sample <= din.end_of_block ? '0 : cur;
    end
  end

endmodule

// ===== src/lec_fifo.sv =====
module lec_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = lec_pkg::FIFO_DEPTH_DEF
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] wdata,
  input  logic             pop,
  output logic [WIDTH-1:0] rdata,
  output logic             full,
  output logic             empty
);
  import lec_pkg::*;

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] entries [DEPTH];
  logic [AW-1:0]    wr_ptr;
  logic [AW-1:0]    rd_ptr;
  logic [CW-1:0]    count;

  assign full  = (count == CW'(DEPTH));
  assign empty = (count == '0);
  assign rdata = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == AW'(DEPTH - 1)) ? '0 : wr_ptr + AW'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == AW'(DEPTH - 1)) ? '0 : rd_ptr + AW'(1);
      end
      if (push && !pop) begin
        count <= count + CW'(1);
      end else if (pop && !push) begin
        count <= count - CW'(1);
      end
    end
  end

endmodule

// ===== src/lec_back.sv =====
module lec_back #(
  parameter int CODE_W = lec_pkg::code_width(lec_pkg::SAMPLE_BITS_DEF),
  parameter int LEN_W  = $clog2(lec_pkg::code_width(lec_pkg::SAMPLE_BITS_DEF) + 1)
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              empty,
  input  logic [CODE_W-1:0] code,
  input  logic [LEN_W-1:0]  len,
  input  logic              eob,
  output logic              pop,
  lec_out_if.source         dout
);
  import lec_pkg::*;

  localparam int ACC_W = CODE_W + PEND_W;
  localparam int CNT_W = $clog2(ACC_W + 1);

  logic              act;
  logic [ACC_W-1:0]  acc;
  logic [CNT_W-1:0]  cnt;
  logic              flush;

  logic              can_emit;
  logic              emit;
  logic              last;
  logic              done;
  logic [BYTE_W-1:0] word;
  logic [CNT_W-1:0]  rem;
  logic [CNT_W-1:0]  cnt_mid;
  logic [PEND_W-1:0] pend;
  logic              load;

  assign can_emit = !dout.valid || dout.ready;
  assign rem      = cnt - CNT_W'(8);

  always_comb begin
    emit    = 1'b0;
    last    = 1'b0;
    done    = 1'b1;
    word    = '0;
    cnt_mid = cnt;
    if (act) begin
      if (cnt >= CNT_W'(8)) begin
        emit    = 1'b1;
        word    = BYTE_W'(acc >> rem);
        last    = (rem < CNT_W'(8)) && !(flush && rem != '0);
        done    = last && can_emit;
        cnt_mid = can_emit ? rem : cnt;
      end else if (flush && cnt != '0) begin
        // Partial byte at the end of a block, zero-padded at the low end.
        emit    = 1'b1;
        word    = acc[BYTE_W-1:0] << (4'd8 - 4'(cnt));
        last    = 1'b1;
        done    = can_emit;
        cnt_mid = can_emit ? '0 : cnt;
      end else begin
        // Word that completes no byte: nothing to send.
        cnt_mid = flush ? '0 : cnt;
      end
    end
  end

  always_comb begin
    for (int i = 0; i < PEND_W; i++) begin
      pend[i] = acc[i] && (i < int'(cnt_mid));
    end
  end

  assign load = done && !empty;
  assign pop  = load;

  always_ff @(posedge clk) begin
    if (rst) begin
      act <= 1'b0;
      cnt <= '0;
    end else if (!emit || can_emit) begin
      if (load) begin
        act <= 1'b1;
        cnt <= cnt_mid + CNT_W'(len);
      end else begin
        act <= act && !done;
        cnt <= cnt_mid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      acc   <= (ACC_W'(pend) << len) | ACC_W'(code);
      flush <= eob;
    end else if (done) begin
      acc   <= ACC_W'(pend);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      dout.valid <= 1'b0;
    end else if (emit && can_emit) begin
      dout.valid <= 1'b1;
    end else if (dout.ready) begin
      dout.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit && can_emit) begin
      dout.out_byte    <= word;
      dout.last_of_run <= last;
    end
  end

endmodule

// ===== src/lec_delta_entropy_encoder_top.sv =====
// Delta entropy encoder for unsigned sensor samples.
// din takes one sample per word with an end_of_block flag; dout delivers the
// packed code stream one byte per word, earliest bit in bit 7, with
// last_of_run marking the final byte caused by an input word.
// The front stage forms the difference to the previous sample and its prefix
// code combinationally and writes it into a small queue; din is ready whenever
// that queue has room, so words can arrive back to back.
// The back stage shifts the code into a byte accumulator and sends one byte
// per cycle while dout is ready; a word yields at most five bytes (four code
// bytes and a padding byte). That byte path sets the sustained rate. With the
// back stage idle, a word passes through the queue and the accumulator before
// its first byte is registered on dout.
// A word that completes no byte and ends no block produces nothing; its bits
// stay pending. When dout stalls the byte register holds, the back stage
// waits, the queue fills and din drops ready. Reset clears the predecessor,
// the pending bits and the queue; no flush pass is needed.
module lec_delta_entropy_encoder_top #(
  parameter int SAMPLE_BITS = lec_pkg::SAMPLE_BITS_DEF,
  parameter int FIFO_DEPTH  = lec_pkg::FIFO_DEPTH_DEF
) (
  input  logic       clk,
  input  logic       rst,
  lec_in_if.sink     din,
  lec_out_if.source  dout
);
  import lec_pkg::*;

  localparam int CODE_W  = code_width(SAMPLE_BITS);
  localparam int LEN_W   = $clog2(CODE_W + 1);
  localparam int ENTRY_W = CODE_W + LEN_W + 1;

  logic               push;
  logic               pop;
  logic               full;
  logic               empty;
  logic [CODE_W-1:0]  f_code;
  logic [LEN_W-1:0]   f_len;
  logic               f_eob;
  logic [CODE_W-1:0]  b_code;
  logic [LEN_W-1:0]   b_len;
  logic               b_eob;
  logic [ENTRY_W-1:0] rdata;

  lec_front #(
    .SAMPLE_BITS(SAMPLE_BITS),
    .CODE_W     (CODE_W),
    .LEN_W      (LEN_W)
  ) u_front (
    .clk (clk),
    .rst (rst),
    .din (din),
    .full(full),
    .push(push),
    .code(f_code),
    .len (f_len),
    .eob (f_eob)
  );

  lec_fifo #(
    .WIDTH(ENTRY_W),
    .DEPTH(FIFO_DEPTH)
  ) u_fifo (
    .clk  (clk),
    .rst  (rst),
    .push (push),
    .wdata({f_eob, f_len, f_code}),
    .pop  (pop),
    .rdata(rdata),
    .full (full),
    .empty(empty)
  );

  assign {b_eob, b_len, b_code} = rdata;

  lec_back #(
    .CODE_W(CODE_W),
    .LEN_W (LEN_W)
  ) u_back (
    .clk  (clk),
    .rst  (rst),
    .empty(empty),
    .code (b_code),
    .len  (b_len),
    .eob  (b_eob),
    .pop  (pop),
    .dout (dout)
  );

`ifndef NO_ASSERTIONS
  a_no_push_full: assert property (@(posedge clk) disable iff (rst) push |-> !full)
    else $error("queue written while full");
  a_no_pop_empty: assert property (@(posedge clk) disable iff (rst) pop |-> !empty)
    else $error("queue read while empty");
  a_reset_idle: assert property (@(posedge clk) rst |=> !dout.valid && !pop)
    else $error("output or queue active right after reset");
`endif

endmodule

// ===== tb/sv/testbench.sv =====
import lec_pkg::*;

typedef struct packed {
  logic [BYTE_W-1:0] code_byte;
  logic              last;
} code_byte_t;

// Tracks the encoder state on the side and keeps the bytes still owed by the block.
class code_byte_tracker;
  logic [SAMPLE_W-1:0] prev_sample;
  logic [PEND_W-1:0]   pend_bits;
  int unsigned         pend_cnt;
  code_byte_t          expected_bytes[$];
  int                  errors;
  int                  bytes_checked;
  int                  samples_noted;
  int                  block_ends;

  function new();
    prev_sample   = '0;
    pend_bits     = '0;
    pend_cnt      = 0;
    errors        = 0;
    bytes_checked = 0;
    samples_noted = 0;
    block_ends    = 0;
  endfunction

  task report(string msg);
    errors++;
    $display("MISMATCH: %s", msg);
  endtask

  // Encodes one accepted sample and queues the bytes it completes.
  function void note_sample(logic [SAMPLE_W-1:0] smp, logic eob);
    int                diff;
    int                mag;
    int                tail;
    int unsigned       nbits;
    int unsigned       plen;
    int unsigned       cnt;
    logic [63:0]       pre;
    logic [63:0]       acc;
    logic [BYTE_W-1:0] produced[$];
    code_byte_t        item;

    diff  = int'(smp) - int'(prev_sample);
    mag   = (diff < 0) ? -diff : diff;
    nbits = 0;
    while ((mag >> nbits) != 0) nbits++;

    // Short lengths have their own table; longer ones are a run of ones ending in zero.
    if (nbits == 0) begin
      pre  = 64'd0;
      plen = 2;
    end else if (nbits < SHORT_LIMIT) begin
      pre  = 64'(nbits + 1);
      plen = 3;
    end else begin
      plen = nbits - 2;
      pre  = (64'd1 << plen) - 64'd2;
    end

    acc = {57'd0, pend_bits};
    cnt = pend_cnt;
    acc = (acc << plen) | pre;
    cnt += plen;

    if (nbits > 0) begin
      tail = (diff > 0) ? diff : diff - 1;
      tail = tail & ((1 << nbits) - 1);
      acc  = (acc << nbits) | 64'(tail);
      cnt += nbits;
    end

    while (cnt >= 8) begin
      cnt -= 8;
      produced.push_back(acc[cnt +: 8]);
      acc &= (64'd1 << cnt) - 64'd1;
    end

    if (eob) begin
      if (cnt > 0) produced.push_back(8'(acc << (8 - cnt)));
      acc         = '0;
      cnt         = 0;
      prev_sample = '0;
      block_ends++;
    end else begin
      prev_sample = smp;
    end

    foreach (produced[i]) begin
      item.code_byte = produced[i];
      item.last      = (i == produced.size() - 1);
      expected_bytes.push_back(item);
    end

    pend_bits = acc[PEND_W-1:0];
    pend_cnt  = cnt;
    samples_noted++;
  endfunction

  task check_byte(logic [BYTE_W-1:0] got, logic got_last);
    code_byte_t want;
    if (expected_bytes.size() == 0) begin
      report($sformatf("byte %02h (last %0b) arrived with nothing expected", got, got_last));
      return;
    end
    want = expected_bytes.pop_front();
    if (got !== want.code_byte)
      report($sformatf("byte %0d: out_byte %02h, expected %02h",
                       bytes_checked, got, want.code_byte));
    if (got_last !== want.last)
      report($sformatf("byte %0d: last_of_run %0b, expected %0b",
                       bytes_checked, got_last, want.last));
    bytes_checked++;
  endtask
endclass

module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int SAMPLE_MAX   = (1 << SAMPLE_W) - 1;
  localparam int RANDOM_WORDS = 146;
  localparam int HOLD_CYCLES  = 300;
  localparam int DRAIN_CYCLES = 20;

  typedef enum int {
    RDY_ALWAYS,
    RDY_RANDOM,
    RDY_SPARSE,
    RDY_MOSTLY
  } ready_mode_t;

  logic clk = 1'b0;
  logic rst;
  logic hold_req;
  logic hold_off;

  ready_mode_t      ready_mode = RDY_ALWAYS;
  int               mode_left  = 0;
  int               phase_cnt  = 0;
  code_byte_tracker tracker;

  lec_in_if  din_if();
  lec_out_if dout_if();

  lec_delta_entropy_encoder_top dut (
    .clk  (clk),
    .rst  (rst),
    .din  (din_if),
    .dout (dout_if)
  );

  always #1 clk = ~clk;

  // Offers one word and returns at the edge where it is taken.
  task send_word(input logic [SAMPLE_W-1:0] smp, input logic eob);
    din_if.valid        <= 1'b1;
    din_if.sample       <= smp;
    din_if.end_of_block <= eob;
    do @(posedge clk); while (!din_if.ready);
    tracker.note_sample(smp, eob);
  endtask

  task idle_for(input int cycles);
    din_if.valid        <= 1'b0;
    din_if.sample       <= SAMPLE_W'($urandom_range(0, SAMPLE_MAX));
    din_if.end_of_block <= 1'($urandom_range(0, 1));
    repeat (cycles) @(posedge clk);
  endtask

  // Receiver: checks every byte taken, then picks ready for the next edge.
  always @(posedge clk) begin
    if (!rst && dout_if.valid && dout_if.ready)
      tracker.check_byte(dout_if.out_byte, dout_if.last_of_run);
    if (mode_left == 0) begin
      ready_mode = ready_mode_t'($urandom_range(0, 3));
      mode_left  = $urandom_range(20, 80);
    end else begin
      mode_left--;
    end
    phase_cnt++;
    if (hold_off) begin
      dout_if.ready <= 1'b0;
    end else begin
      case (ready_mode)
        RDY_ALWAYS: dout_if.ready <= 1'b1;
        RDY_RANDOM: dout_if.ready <= 1'($urandom_range(0, 1));
        RDY_SPARSE: dout_if.ready <= (phase_cnt % 3) == 0;
        default:    dout_if.ready <= $urandom_range(0, 4) != 0;
      endcase
    end
  end

  // Long receiver stall, so the internal queue fills and din drops ready.
  initial begin
    hold_off <= 1'b0;
    wait (hold_req === 1'b1);
    @(posedge clk);
    hold_off <= 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk);
    hold_off <= 1'b0;
  end

  initial begin
    #200000;
    $display("Timeout with %0d bytes still expected.", tracker.expected_bytes.size());
    $display("lec_delta_entropy_encoder_top verification failed");
    $finish;
  end

  initial begin : stimulus
    logic [SAMPLE_W-1:0] base;
    logic [SAMPLE_W-1:0] smp;
    logic                eob;
    int                  nbits;
    int                  mag;
    int                  pick;
    int                  sent;
    int                  burst;
    int                  gap;
    int                  hold_at;
    bit                  hold_done;

    tracker = new();
    rst                 <= 1'b1;
    hold_req            <= 1'b0;
    din_if.valid        <= 1'b0;
    din_if.sample       <= '0;
    din_if.end_of_block <= 1'b0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // Difference lengths zero to five and fourteen, most with both signs, from the reset predecessor.
    send_word(14'd0, 1'b0);
    send_word(14'd1, 1'b0);
    send_word(14'd0, 1'b0);
    send_word(14'd3, 1'b0);
    send_word(14'd0, 1'b0);
    send_word(14'd7, 1'b0);
    send_word(14'd0, 1'b0);
    send_word(14'd15, 1'b0);
    send_word(14'd0, 1'b0);
    send_word(SAMPLE_W'(SAMPLE_MAX), 1'b0);
    send_word(14'd0, 1'b0);
    send_word(14'd31, 1'b1);
    // Four zero differences fill exactly one byte, so the block end has nothing to pad.
    send_word(14'd0, 1'b0);
    send_word(14'd0, 1'b0);
    send_word(14'd0, 1'b0);
    send_word(14'd0, 1'b1);
    // Seven bits pending, then the longest code and a flush: five bytes from one word.
    send_word(14'd10, 1'b0);
    send_word(SAMPLE_W'(SAMPLE_MAX), 1'b1);
    send_word(14'd8192, 1'b0);
    send_word(14'd0, 1'b0);
    send_word(14'd100, 1'b0);
    send_word(14'd36, 1'b1);
    send_word(14'h2aaa, 1'b0);
    send_word(14'h1555, 1'b1);

    base      = '0;
    sent      = 0;
    hold_done = 1'b0;
    hold_at   = $urandom_range(40, 100);
    while (sent < RANDOM_WORDS) begin
      burst = $urandom_range(1, 12);
      if (!hold_done && sent >= hold_at) begin
        hold_req  <= 1'b1;
        hold_done = 1'b1;
        burst     = 24;
      end
      repeat (burst) begin
        pick = $urandom_range(0, 9);
        if (pick <= 5) begin
          // Mostly steer the difference to a chosen bit length.
          nbits = $urandom_range(0, SAMPLE_W);
          mag   = (nbits == 0) ? 0
                : ((1 << (nbits - 1)) | $urandom_range(0, (1 << (nbits - 1)) - 1));
          if ($urandom_range(0, 1) && int'(base) >= mag)
            smp = SAMPLE_W'(int'(base) - mag);
          else if (int'(base) + mag <= SAMPLE_MAX)
            smp = SAMPLE_W'(int'(base) + mag);
          else if (int'(base) >= mag)
            smp = SAMPLE_W'(int'(base) - mag);
          else
            smp = SAMPLE_W'($urandom_range(0, SAMPLE_MAX));
        end else if (pick <= 7) begin
          smp = SAMPLE_W'($urandom_range(0, SAMPLE_MAX));
        end else if (pick == 8) begin
          smp = SAMPLE_W'($urandom_range(0, 1) ? SAMPLE_MAX : 0);
        end else begin
          smp = base;
        end
        eob = ($urandom_range(0, 11) == 0);
        send_word(smp, eob);
        base = eob ? '0 : smp;
        sent++;
      end
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap > 0) idle_for(gap);
    end

    din_if.valid <= 1'b0;
    while (tracker.expected_bytes.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Run covered %0d samples with %0d block ends and %0d code bytes checked,",
             tracker.samples_noted, tracker.block_ends, tracker.bytes_checked);
    $display("including a %0d-cycle receiver stall with input back-pressure.", HOLD_CYCLES);
    if (tracker.errors == 0) begin
      $display("lec_delta_entropy_encoder_top verification clean");
    end else begin
      $display("%0d mismatches.", tracker.errors);
      $display("lec_delta_entropy_encoder_top verification failed");
    end
    $finish;
  end
endmodule
